@@ sv/ntbe_pkg.sv @@
package ntbe_pkg;

  localparam int NUM_PATTERNS_DEF = 8;
  localparam int SYMMETRIES_DEF   = 8;
  localparam int TUPLE_LEN_DEF    = 5;
  localparam int WEIGHT_BITS_DEF  = 32;

  localparam int BOARD_W       = 64;
  localparam int DELTA_W       = 32;
  localparam int VALUE_W       = 38;
  localparam int SYM_IDX_W     = 3;
  localparam int MAX_TUPLE_LEN = 6;
  localparam int IDX_MAX_W     = 4 * MAX_TUPLE_LEN;
  localparam int NUM_BASE      = 8;
  localparam int BASE_LEN      = 5;

  // symmetry codes of the 4x4 square
  localparam logic [SYM_IDX_W-1:0] SYM_IDENT = 3'd0;
  localparam logic [SYM_IDX_W-1:0] SYM_ROT90 = 3'd1;
  localparam logic [SYM_IDX_W-1:0] SYM_ROT180 = 3'd2;
  localparam logic [SYM_IDX_W-1:0] SYM_ROT270 = 3'd3;
  localparam logic [SYM_IDX_W-1:0] SYM_MIRC = 3'd4;
  localparam logic [SYM_IDX_W-1:0] SYM_MIRR = 3'd5;
  localparam logic [SYM_IDX_W-1:0] SYM_DIAG = 3'd6;

  localparam logic [3:0] PATTERN_SQUARES [NUM_BASE][BASE_LEN] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4},
    '{4'd4, 4'd5, 4'd6, 4'd7, 4'd8},
    '{4'd0, 4'd1, 4'd2, 4'd4, 4'd5},
    '{4'd4, 4'd5, 4'd6, 4'd8, 4'd9},
    '{4'd0, 4'd1, 4'd4, 4'd5, 4'd8},
    '{4'd1, 4'd2, 4'd5, 4'd6, 4'd9},
    '{4'd0, 4'd1, 4'd2, 4'd5, 4'd6},
    '{4'd1, 4'd5, 4'd6, 4'd9, 4'd10}
  };

  typedef logic [IDX_MAX_W-1:0] idx_t;

  typedef struct packed {
    logic                 start;
    logic                 clr;
    logic                 rd;
    logic                 acc;
    logic                 wr;
    logic [SYM_IDX_W-1:0] sym;
  } lane_ctl_t;

  function automatic logic [3:0] sym_cell(input logic [SYM_IDX_W-1:0] s,
                                          input logic [3:0] sq);
    logic [1:0] r;
    logic [1:0] c;
    logic [1:0] orow;
    logic [1:0] ocol;
    r = sq[3:2];
    c = sq[1:0];
    case (s)
      SYM_IDENT: begin orow = r;  ocol = c;  end
      SYM_ROT90: begin orow = c;  ocol = ~r; end
      SYM_ROT180: begin orow = ~r; ocol = ~c; end
      SYM_ROT270: begin orow = ~c; ocol = r;  end
      SYM_MIRC: begin orow = r;  ocol = ~c; end
      SYM_MIRR: begin orow = ~r; ocol = c;  end
      SYM_DIAG: begin orow = c;  ocol = r;  end
      default: begin orow = ~c; ocol = ~r; end
    endcase
    return {orow, ocol};
  endfunction

  // first tuple cell lands in the lowest nibble
  function automatic idx_t pack_index(input logic [BOARD_W-1:0] board,
                                      input logic [3:0] p,
                                      input logic [SYM_IDX_W-1:0] s,
                                      input int tl);
    idx_t       idx;
    logic [3:0] sq;
    logic [2:0] kb;
    idx = '0;
    for (int k = 0; k < MAX_TUPLE_LEN; k++) begin
      if (k < tl) begin
        kb = (k == BASE_LEN) ? 3'd0 : 3'(k);
        sq = sym_cell(s, PATTERN_SQUARES[p[2:0]][kb]);
        idx[4*k +: 4] = board[{sq, 2'b00} +: 4];
      end
    end
    return idx;
  endfunction

endpackage

@@ sv/ntbe_ram.sv @@
module ntbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/ntbe_qdiv.sv @@
module ntbe_qdiv #(
  parameter int DIVISOR = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [ntbe_pkg::DELTA_W-1:0] delta,
  output logic signed [ntbe_pkg::DELTA_W-1:0] q,
  output logic                                ready
);
  import ntbe_pkg::*;

  // floor(delta / DIVISOR)
  if ((DIVISOR & (DIVISOR - 1)) == 0) begin : g_shift
    localparam int SH = $clog2(DIVISOR);
    logic signed [DELTA_W-1:0] q_r;
    logic                      ready_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ready_r <= 1'b0;
      end else if (start) begin
        ready_r <= 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        q_r <= delta >>> SH;
      end
    end

    assign q     = q_r;
    assign ready = ready_r;
  end else begin : g_recip
    // (n * M) >> SH equals floor(n / DIVISOR) for every 32-bit n
    localparam int     L   = $clog2(DIVISOR);
    localparam int     SH  = DELTA_W + L;
    localparam longint M_L = ((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
    // bit DELTA_W of the multiplier is always set
    localparam logic [DELTA_W-1:0] M_LO = DELTA_W'(M_L);
    localparam logic [DELTA_W-1:0] BIAS = DELTA_W'(DIVISOR - 1);

    logic [DELTA_W-1:0]        mag_r;
    logic                      neg_r;
    logic                      pend_r;
    logic signed [DELTA_W-1:0] q_r;
    logic [2*DELTA_W-1:0]      plo;
    logic [2*DELTA_W:0]        prod;
    logic [DELTA_W-1:0]        qm;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pend_r <= 1'b0;
      end else begin
        pend_r <= start;
      end
    end

    // negative: minus the ceiling of the magnitude quotient
    always_ff @(posedge clk) begin
      if (start) begin
        mag_r <= delta[DELTA_W-1] ? $unsigned(-delta) + BIAS : $unsigned(delta);
        neg_r <= delta[DELTA_W-1];
      end
      if (pend_r) begin
        q_r <= neg_r ? -qm : qm;
      end
    end

    assign plo   = {{DELTA_W{1'b0}}, mag_r} * {{DELTA_W{1'b0}}, M_LO};
    assign prod  = {1'b0, mag_r, {DELTA_W{1'b0}}} + {1'b0, plo};
    assign qm    = DELTA_W'(prod >> SH);
    assign q     = q_r;
    assign ready = !pend_r;
  end

endmodule

@@ sv/ntbe_lane.sv @@
module ntbe_lane #(
  parameter int LANE        = 0,
  parameter int TUPLE_LEN   = ntbe_pkg::TUPLE_LEN_DEF,
  parameter int WEIGHT_BITS = ntbe_pkg::WEIGHT_BITS_DEF,
  parameter int LSW         = ntbe_pkg::WEIGHT_BITS_DEF + ntbe_pkg::SYM_IDX_W
) (
  input  logic                                clk,
  input  ntbe_pkg::lane_ctl_t                 ctl,
  input  logic [4*TUPLE_LEN-1:0]              clr_addr,
  input  logic [ntbe_pkg::BOARD_W-1:0]        board,
  input  logic signed [ntbe_pkg::DELTA_W-1:0] q,
  output logic signed [LSW-1:0]               lane_sum,
  output logic                                sat
);
  import ntbe_pkg::*;

  localparam int AW    = 4 * TUPLE_LEN;
  localparam int DEPTH = 1 << AW;
  localparam int EW    = DELTA_W + 2;
  localparam longint WMAX_L = (longint'(1) << (WEIGHT_BITS - 1)) - 1;
  localparam logic signed [EW-1:0] WMAX = EW'(WMAX_L);
  localparam logic signed [EW-1:0] WMIN = EW'(-WMAX_L - 1);

  logic [AW-1:0]                 idx;
  logic [WEIGHT_BITS-1:0]        rdata;
  logic [WEIGHT_BITS-1:0]        wsat;
  logic [WEIGHT_BITS-1:0]        wdata;
  logic [AW-1:0]                 waddr;
  logic                          we;
  logic signed [EW-1:0]          wsum;
  logic                          clip_hi;
  logic                          clip_lo;
  logic signed [LSW-1:0]         sum_r;
  logic                          sat_r;

  assign idx = AW'(pack_index(board, 4'(LANE), ctl.sym, TUPLE_LEN));

  assign wsum    = EW'($signed(rdata)) + EW'(q);
  assign clip_hi = wsum > WMAX;
  assign clip_lo = wsum < WMIN;
  assign wsat    = clip_hi ? WMAX[WEIGHT_BITS-1:0] :
                   clip_lo ? WMIN[WEIGHT_BITS-1:0] : wsum[WEIGHT_BITS-1:0];

  assign we    = ctl.clr | ctl.wr;
  assign waddr = ctl.clr ? clr_addr : idx;
  assign wdata = ctl.clr ? '0 : wsat;

  ntbe_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctl.rd),
    .raddr (idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      sum_r <= '0;
      sat_r <= 1'b0;
    end else begin
      if (ctl.acc) begin
        sum_r <= sum_r + LSW'($signed(rdata));
      end
      if (ctl.wr && (clip_hi || clip_lo)) begin
        sat_r <= 1'b1;
      end
    end
  end

  assign lane_sum = sum_r;
  assign sat      = sat_r;

endmodule

@@ sv/ntbe_merge.sv @@
module ntbe_merge #(
  parameter int NUM_PATTERNS = ntbe_pkg::NUM_PATTERNS_DEF,
  parameter int LSW          = ntbe_pkg::WEIGHT_BITS_DEF + ntbe_pkg::SYM_IDX_W
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [LSW-1:0]               lane_sum [NUM_PATTERNS],
  output logic signed [ntbe_pkg::VALUE_W-1:0] total,
  output logic                                busy
);
  import ntbe_pkg::*;

  localparam int MW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;

  logic [MW-1:0]              cnt_r;
  logic                       busy_r;
  logic signed [VALUE_W-1:0]  total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == MW'(NUM_PATTERNS - 1)) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // one lane per cycle; wraps at the result width
  always_ff @(posedge clk) begin
    if (start) begin
      total_r <= '0;
    end else if (busy_r) begin
      total_r <= total_r + VALUE_W'(lane_sum[cnt_r]);
    end
  end

  assign total = total_r;
  assign busy  = busy_r;

endmodule

@@ sv/ntuple_board_evaluator_top.sv @@
// Evaluate: the result is set by one read per cycle from each pattern lane's RAM, then
// the lane-by-lane merge. Update: the merge runs alongside the update pass, in which, after
// the reads, each weight takes a read-modify-write (a read state, then a write state).
// One request at a time: the next beat is taken in the cycle after the result loads.
// Reset: a clear pass writes zero to 2^(4*TUPLE_LEN) rows, in_stall held high.
module ntuple_board_evaluator_top #(
  parameter int NUM_PATTERNS = ntbe_pkg::NUM_PATTERNS_DEF,
  parameter int SYMMETRIES   = ntbe_pkg::SYMMETRIES_DEF,
  parameter int TUPLE_LEN    = ntbe_pkg::TUPLE_LEN_DEF,
  parameter int WEIGHT_BITS  = ntbe_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic [ntbe_pkg::BOARD_W-1:0]        in_board,
  input  logic signed [ntbe_pkg::DELTA_W-1:0] in_delta,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ntbe_pkg::VALUE_W-1:0] out_board_value,
  output logic                                out_weight_saturated
);
  import ntbe_pkg::*;

  localparam int AW      = 4 * TUPLE_LEN;
  localparam int TOUCHED = NUM_PATTERNS * SYMMETRIES;
  localparam int LSW     = WEIGHT_BITS + SYM_IDX_W;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_RTAIL  = 3'd3;
  localparam logic [2:0] ST_QWAIT  = 3'd4;
  localparam logic [2:0] ST_UPD_RD = 3'd5;
  localparam logic [2:0] ST_UPD_WR = 3'd6;
  localparam logic [2:0] ST_WAIT   = 3'd7;

  logic [2:0]                state_r, state_nxt;
  logic [SYM_IDX_W-1:0]      sym_r, sym_nxt;
  logic [AW-1:0]             clr_cnt_r, clr_cnt_nxt;
  logic                      acc_r;
  logic                      mstart_r;
  logic                      req_r;
  logic [BOARD_W-1:0]        board_r;
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic                      out_sat_r;

  logic                      accept;
  logic                      sym_last;
  logic                      ld_out;
  lane_ctl_t                 ctl;
  logic signed [DELTA_W-1:0] q;
  logic                      q_ready;
  logic signed [LSW-1:0]     lane_sum [NUM_PATTERNS];
  logic [NUM_PATTERNS-1:0]   lane_sat;
  logic signed [VALUE_W-1:0] total;
  logic                      merge_busy;

  assign in_stall = state_r != ST_IDLE;
  assign accept   = in_valid && !in_stall;
  assign sym_last = sym_r == SYM_IDX_W'(SYMMETRIES - 1);
  assign ld_out   = (state_r == ST_WAIT) && !mstart_r && !merge_busy &&
                    (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt   = state_r;
    sym_nxt     = sym_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_READ;
          sym_nxt   = '0;
        end
      end
      ST_READ: begin
        if (sym_last) begin
          state_nxt = ST_RTAIL;
          sym_nxt   = '0;
        end else begin
          sym_nxt = sym_r + 1'b1;
        end
      end
      ST_RTAIL: begin
        state_nxt = req_r ? ST_QWAIT : ST_WAIT;
      end
      ST_QWAIT: begin
        if (q_ready) begin
          state_nxt = ST_UPD_RD;
        end
      end
      ST_UPD_RD: begin
        state_nxt = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        if (sym_last) begin
          state_nxt = ST_WAIT;
          sym_nxt   = '0;
        end else begin
          state_nxt = ST_UPD_RD;
          sym_nxt   = sym_r + 1'b1;
        end
      end
      ST_WAIT: begin
        if (ld_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sym_r       <= '0;
      clr_cnt_r   <= '0;
      acc_r       <= 1'b0;
      mstart_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sym_r     <= sym_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      acc_r     <= state_r == ST_READ;
      mstart_r  <= state_r == ST_RTAIL;
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req_type;
      board_r <= in_board;
    end
    if (ld_out) begin
      out_value_r <= total;
      out_sat_r   <= |lane_sat;
    end
  end

  always_comb begin
    ctl.start = accept;
    ctl.clr   = state_r == ST_CLEAR;
    ctl.rd    = (state_r == ST_READ) || (state_r == ST_UPD_RD);
    ctl.acc   = acc_r;
    ctl.wr    = state_r == ST_UPD_WR;
    ctl.sym   = sym_r;
  end

  ntbe_qdiv #(
    .DIVISOR (TOUCHED)
  ) u_qdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .delta (in_delta),
    .q     (q),
    .ready (q_ready)
  );

  for (genvar g = 0; g < NUM_PATTERNS; g++) begin : g_lane
    ntbe_lane #(
      .LANE        (g),
      .TUPLE_LEN   (TUPLE_LEN),
      .WEIGHT_BITS (WEIGHT_BITS),
      .LSW         (LSW)
    ) u_lane (
      .clk      (clk),
      .ctl      (ctl),
      .clr_addr (clr_cnt_r),
      .board    (board_r),
      .q        (q),
      .lane_sum (lane_sum[g]),
      .sat      (lane_sat[g])
    );
  end

  ntbe_merge #(
    .NUM_PATTERNS (NUM_PATTERNS),
    .LSW          (LSW)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mstart_r),
    .lane_sum (lane_sum),
    .total    (total),
    .busy     (merge_busy)
  );

  assign out_valid            = out_valid_r;
  assign out_board_value      = out_value_r;
  assign out_weight_saturated = out_sat_r;

`ifndef NO_ASSERTIONS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> in_stall)
    else $error("input beat taken during clear pass");

  a_merge_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!merge_busy && !mstart_r))
    else $error("merge still running while idle");

  a_q_ready_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD_RD || state_r == ST_UPD_WR) |-> q_ready)
    else $error("update pass without correction ready");

  a_eval_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_out && !req_r) |=> !out_weight_saturated)
    else $error("saturation flagged on evaluate beat");
`endif

endmodule
